@@ hdl/hfdp_pkg.sv @@
// Shared types, constants and helper functions for the half-precision dot product.
// Used by every design module of the block; depends on nothing else.
`timescale 1ns / 1ps

package hfdp_pkg;

  localparam int LANES_DEF = 8;

  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [15:0] F16_QNAN = 16'h7E00;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DEC,
    S_RDA,
    S_RDB,
    S_LDB,
    S_WAIT,
    S_WB,
    S_ROOT,
    S_ROOTLD,
    S_TRD,
    S_TLD,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_FLUSH,
    PH_RED,
    PH_TAIL
  } phase_e;

  typedef enum logic [1:0] {
    OPA_HOLD,
    OPA_LANE,
    OPA_ACC
  } opa_sel_e;

  typedef enum logic [1:0] {
    OPB_HOLD,
    OPB_LANE,
    OPB_PEND,
    OPB_PROD
  } opb_sel_e;

  typedef struct packed {
    logic     in_load;
    opa_sel_e opa_sel;
    opb_sel_e opb_sel;
    logic     lane_we;
    logic     lane_clr;
    logic     pend_we;
    logic     acc_from_lane;
    logic     acc_from_sum;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

  localparam int RED_A    = 0;
  localparam int RED_B    = 1;
  localparam int RED_ROOT = 2;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Walks the lane reduction order: fold the upper half onto the lower half while
  // more than four sums remain, then add adjacent pairs. Each add writes into the
  // register that holds its first operand. Returns operand a or b of add number k,
  // or the register that holds the final sum.
  function automatic int red_op(input int lanes, input int k, input int sel);
    int s [16];
    int n;
    int h;
    int c;
    int r;
    n = lanes;
    c = 0;
    r = 0;
    for (int i = 0; i < 16; i++) s[i] = i;
    for (int p = 0; p < 8; p++) begin
      if (n > 4) begin
        h = n >> 1;
        for (int i = 0; i < 8; i++) begin
          if (i < h) begin
            if (c == k) r = (sel == RED_B) ? s[i + h] : s[i];
            c++;
          end
        end
        if ((n & 1) != 0) begin
          s[h] = s[n - 1];
          n = h + 1;
        end else begin
          n = h;
        end
      end
    end
    for (int p = 0; p < 8; p++) begin
      if (n > 1) begin
        h = n >> 1;
        for (int i = 0; i < 8; i++) begin
          if (i < h) begin
            if (c == k) r = (sel == RED_B) ? s[2 * i + 1] : s[2 * i];
            c++;
            s[i] = s[2 * i];
          end
        end
        if ((n & 1) != 0) begin
          s[h] = s[n - 1];
          n = h + 1;
        end else begin
          n = h;
        end
      end
    end
    if (sel == RED_ROOT) r = s[0];
    return r;
  endfunction

  // Leading zero count of a 27-bit word; 27 when the word is zero.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

endpackage

@@ hdl/half_float_dot_product.sv @@
// An accepted item stalls the input while it passes two product stages and a decision
// step. Completing a block adds a flush through every lane. A last item adds the
// reduction adds (Lanes - 1 adds), the root, each held product, then the output.
// Throughput: one item at a time; every lane update goes through the one four-stage adder.
// Reset (rst_ni, async, active low) clears control, lane valid bits and output valid only.
`timescale 1ns / 1ps

module half_float_dot_product import hfdp_pkg::*; #(
  parameter int Lanes = LANES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] x_half_i,
  input  logic [15:0] w_half_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] dot_half_o
);

  localparam int LW  = $clog2(Lanes);
  localparam int PAW = addr_w(Lanes - 1);

  // The controller steps through one input transaction at a time. Each product is
  // formed exactly by the product stages. Products of an unfinished block sit in a small
  // RAM; when a block completes, each lane sum is updated through the shared adder.
  // On the last transaction the lanes are folded into one sum in the fixed order
  // of the reduction table, any held products are added in order, and the rounded
  // half-precision value is placed in the output register. The output register
  // parts the two channels, so a waiting result does not block a new transaction.
  cmd_t           cmd;
  status_t        st;
  logic [LW-1:0]  lane_raddr, lane_waddr;
  logic [PAW-1:0] pend_addr;

  hfdp_ctrl #(.Lanes(Lanes)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .st_i         (st),
    .cmd_o        (cmd),
    .lane_raddr_o (lane_raddr),
    .lane_waddr_o (lane_waddr),
    .pend_addr_o  (pend_addr)
  );

  hfdp_dpath #(.Lanes(Lanes)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .x_half_i       (x_half_i),
    .w_half_i       (w_half_i),
    .last_element_i (last_element_i),
    .cmd_i          (cmd),
    .lane_raddr_i   (lane_raddr),
    .lane_waddr_i   (lane_waddr),
    .pend_addr_i    (pend_addr),
    .st_o           (st),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .dot_half_o     (dot_half_o)
  );

endmodule

@@ hdl/hfdp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on hfdp_pkg for the address width helper.
`timescale 1ns / 1ps

module hfdp_ram import hfdp_pkg::*; #(
  parameter int Width = 32,
  parameter int Depth = 8,
  localparam int AW = addr_w(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/hfdp_fadd.sv @@
// Four-stage pipelined binary32 adder, round to nearest even, with subnormals.
// Stages: align, add, normalize, round. Depends on hfdp_pkg.
`timescale 1ns / 1ps

module hfdp_fadd import hfdp_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);

  // Align stage.
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, dexp;
  logic [26:0] mbx, msx, al;
  logic        spec_a;
  logic [31:0] sval_a;

  logic        s1_sign_q, s1_sub_q, s1_spec_q;
  logic [31:0] s1_sval_q;
  logic [8:0]  s1_exp_q;
  logic [26:0] s1_big_q, s1_sml_q;

  always_comb begin
    a_nan = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    spec_a = a_nan || b_nan || a_inf || b_inf;
    if (a_nan || b_nan || (a_inf && b_inf && (a_i[31] != b_i[31]))) begin
      sval_a = F32_QNAN;
    end else if (a_inf) begin
      sval_a = {a_i[31], 8'hFF, 23'd0};
    end else begin
      sval_a = {b_i[31], 8'hFF, 23'd0};
    end
    swap = b_i[30:0] > a_i[30:0];
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    dexp = eb - es;
    mbx  = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    msx  = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    if (dexp >= 8'd27) begin
      al = {26'd0, (msx != 27'd0)};
    end else begin
      al = msx >> dexp;
      al[0] = al[0] | ((msx & ((27'd1 << dexp) - 27'd1)) != 27'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sign_q <= big[31];
    s1_sub_q  <= a_i[31] ^ b_i[31];
    s1_spec_q <= spec_a;
    s1_sval_q <= sval_a;
    s1_exp_q  <= {1'b0, eb};
    s1_big_q  <= mbx;
    s1_sml_q  <= al;
  end

  // Add stage.
  logic        s2_sign_q, s2_sub_q, s2_spec_q;
  logic [31:0] s2_sval_q;
  logic [8:0]  s2_exp_q;
  logic [27:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    s2_sign_q <= s1_sign_q;
    s2_sub_q  <= s1_sub_q;
    s2_spec_q <= s1_spec_q;
    s2_sval_q <= s1_sval_q;
    s2_exp_q  <= s1_exp_q;
    s2_sum_q  <= s1_sub_q ? ({1'b0, s1_big_q} - {1'b0, s1_sml_q})
                          : ({1'b0, s1_big_q} + {1'b0, s1_sml_q});
  end

  // Normalize stage: the left shift stops at the subnormal boundary.
  logic [4:0]  lz, shl;
  logic [8:0]  lim;
  logic [26:0] nm;
  logic [8:0]  ne;

  logic        s3_sign_q, s3_zsign_q, s3_spec_q, s3_zero_q;
  logic [31:0] s3_sval_q;
  logic [8:0]  s3_exp_q;
  logic [26:0] s3_m_q;

  always_comb begin
    lz  = lzc27(s2_sum_q[26:0]);
    lim = s2_exp_q - 9'd1;
    shl = ({4'd0, lz} < lim) ? lz : lim[4:0];
    if (s2_sum_q[27]) begin
      nm = {s2_sum_q[27:2], s2_sum_q[1] | s2_sum_q[0]};
      ne = s2_exp_q + 9'd1;
    end else begin
      nm = s2_sum_q[26:0] << shl;
      ne = s2_exp_q - {4'd0, shl};
    end
  end

  always_ff @(posedge clk_i) begin
    s3_sign_q  <= s2_sign_q;
    s3_zsign_q <= s2_sub_q ? 1'b0 : s2_sign_q;
    s3_spec_q  <= s2_spec_q;
    s3_sval_q  <= s2_sval_q;
    s3_zero_q  <= (s2_sum_q == 28'd0);
    s3_exp_q   <= ne;
    s3_m_q     <= nm;
  end

  // Round stage. A carry out of the fraction moves into the exponent field.
  logic [8:0]  ef;
  logic        rnd;
  logic [30:0] mag;
  logic [31:0] res;
  logic [31:0] res_q;

  always_comb begin
    ef  = s3_m_q[26] ? s3_exp_q : 9'd0;
    rnd = s3_m_q[2] && (s3_m_q[1] || s3_m_q[0] || s3_m_q[3]);
    mag = {ef[7:0], s3_m_q[25:3]} + {30'd0, rnd};
    if (s3_spec_q) begin
      res = s3_sval_q;
    end else if (s3_zero_q) begin
      res = {s3_zsign_q, 31'd0};
    end else if (ef >= 9'd255) begin
      res = {s3_sign_q, 8'hFF, 23'd0};
    end else begin
      res = {s3_sign_q, mag};
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res;
  end

  assign sum_o = res_q;

endmodule

@@ hdl/hfdp_dpath.sv @@
// Datapath: input capture, exact product, lane and held-product RAMs, adder, output.
// Depends on hfdp_pkg, hfdp_ram and hfdp_fadd.
`timescale 1ns / 1ps

module hfdp_dpath import hfdp_pkg::*; #(
  parameter int Lanes = LANES_DEF,
  localparam int LW  = $clog2(Lanes),
  localparam int PAW = addr_w(Lanes - 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    x_half_i,
  input  logic [15:0]    w_half_i,
  input  logic           last_element_i,
  input  cmd_t           cmd_i,
  input  logic [LW-1:0]  lane_raddr_i,
  input  logic [LW-1:0]  lane_waddr_i,
  input  logic [PAW-1:0] pend_addr_i,
  output status_t        st_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic [15:0]    dot_half_o
);

  logic [15:0] x_q, w_q;
  logic        last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q    <= x_half_i;
      w_q    <= w_half_i;
      last_q <= last_element_i;
    end
  end

  // Product, first stage: significand multiply and classification.
  logic [4:0]  ex, ew;
  logic        x_nan, w_nan, x_inf, w_inf, x_zero, w_zero;
  logic [21:0] p1_int_q;
  logic [5:0]  p1_exp_q;
  logic        p1_sign_q, p1_nan_q, p1_inf_q, p1_zero_q;

  always_comb begin
    ex     = (x_q[14:10] == 5'd0) ? 5'd1 : x_q[14:10];
    ew     = (w_q[14:10] == 5'd0) ? 5'd1 : w_q[14:10];
    x_nan  = (x_q[14:10] == 5'h1F) && (x_q[9:0] != 10'd0);
    w_nan  = (w_q[14:10] == 5'h1F) && (w_q[9:0] != 10'd0);
    x_inf  = (x_q[14:10] == 5'h1F) && (x_q[9:0] == 10'd0);
    w_inf  = (w_q[14:10] == 5'h1F) && (w_q[9:0] == 10'd0);
    x_zero = (x_q[14:0] == 15'd0);
    w_zero = (w_q[14:0] == 15'd0);
  end

  always_ff @(posedge clk_i) begin
    p1_int_q  <= {(x_q[14:10] != 5'd0), x_q[9:0]} * {(w_q[14:10] != 5'd0), w_q[9:0]};
    p1_exp_q  <= {1'b0, ex} + {1'b0, ew};
    p1_sign_q <= x_q[15] ^ w_q[15];
    p1_nan_q  <= x_nan || w_nan || (x_inf && w_zero) || (w_inf && x_zero);
    p1_inf_q  <= x_inf || w_inf;
    p1_zero_q <= x_zero || w_zero;
  end

  // Product, second stage: normalize to binary32. Always exact.
  logic [4:0]  plz;
  logic [26:0] pnorm;
  logic [7:0]  pexp;
  logic [31:0] prod_q;

  always_comb begin
    plz   = lzc27({p1_int_q, 5'd0});
    pnorm = {p1_int_q, 5'd0} << plz;
    pexp  = 8'({2'd0, p1_exp_q} + 8'd98 - {3'd0, plz});
  end

  always_ff @(posedge clk_i) begin
    if (p1_nan_q) begin
      prod_q <= F32_QNAN;
    end else if (p1_inf_q) begin
      prod_q <= {p1_sign_q, 8'hFF, 23'd0};
    end else if (p1_zero_q) begin
      prod_q <= {p1_sign_q, 31'd0};
    end else begin
      prod_q <= {p1_sign_q, pexp, pnorm[25:3]};
    end
  end

  // Lane sums: RAM plus one valid bit per lane; an invalid lane reads as +0.
  logic [31:0] sum;
  logic [31:0] lane_rdata, lane_data;
  logic [Lanes-1:0] lane_vld_q;
  logic        lane_rv_q;

  hfdp_ram #(.Width(32), .Depth(Lanes)) u_lane_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.lane_we),
    .waddr_i (lane_waddr_i),
    .wdata_i (sum),
    .raddr_i (lane_raddr_i),
    .rdata_o (lane_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= '0;
      lane_rv_q  <= 1'b0;
    end else begin
      lane_rv_q <= lane_vld_q[lane_raddr_i];
      if (cmd_i.lane_clr) begin
        lane_vld_q <= '0;
      end else if (cmd_i.lane_we) begin
        lane_vld_q[lane_waddr_i] <= 1'b1;
      end
    end
  end

  assign lane_data = lane_rv_q ? lane_rdata : 32'd0;

  logic [31:0] pend_rdata;

  hfdp_ram #(.Width(32), .Depth(Lanes - 1)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pend_we),
    .waddr_i (pend_addr_i),
    .wdata_i (prod_q),
    .raddr_i (pend_addr_i),
    .rdata_o (pend_rdata)
  );

  // Adder operands and accumulator.
  logic [31:0] opa_q, opb_q, acc_q;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.opa_sel)
      OPA_LANE: opa_q <= lane_data;
      OPA_ACC:  opa_q <= acc_q;
      default:  opa_q <= opa_q;
    endcase
    unique case (cmd_i.opb_sel)
      OPB_LANE: opb_q <= lane_data;
      OPB_PEND: opb_q <= pend_rdata;
      OPB_PROD: opb_q <= prod_q;
      default:  opb_q <= opb_q;
    endcase
    if (cmd_i.acc_from_lane) begin
      acc_q <= lane_data;
    end else if (cmd_i.acc_from_sum) begin
      acc_q <= sum;
    end
  end

  hfdp_fadd u_fadd (
    .clk_i (clk_i),
    .a_i   (opa_q),
    .b_i   (opb_q),
    .sum_o (sum)
  );

  // Binary32 to binary16, round to nearest even.
  logic        hs;
  logic [7:0]  he;
  logic [22:0] hmant;
  logic [15:0] hm, half_res;
  logic [12:0] hrem;
  logic [4:0]  sh;
  logic [23:0] m24, sub_hm, sub_rem, sub_half;

  always_comb begin
    hs       = acc_q[31];
    he       = acc_q[30:23];
    hmant    = acc_q[22:0];
    hrem     = hmant[12:0];
    hm       = {1'b0, 5'(he - 8'd112), hmant[22:13]};
    sh       = 5'(8'd126 - he);
    m24      = {1'b1, hmant};
    sub_hm   = m24 >> sh;
    sub_rem  = m24 & ((24'd1 << sh) - 24'd1);
    sub_half = 24'd1 << (sh - 5'd1);
    if (he == 8'hFF) begin
      half_res = (hmant != 23'd0) ? F16_QNAN : {hs, 15'h7C00};
    end else if (he >= 8'd143) begin
      half_res = {hs, 15'h7C00};
    end else if (he >= 8'd113) begin
      if ((hrem > 13'h1000) || ((hrem == 13'h1000) && hm[0])) begin
        half_res = {hs, 15'd0} | (hm + 16'd1);
      end else begin
        half_res = {hs, 15'd0} | hm;
      end
    end else if ((he == 8'd0) || (he <= 8'd101)) begin
      half_res = {hs, 15'd0};
    end else begin
      if ((sub_rem > sub_half) || ((sub_rem == sub_half) && sub_hm[0])) begin
        half_res = {hs, 15'd0} | (sub_hm[15:0] + 16'd1);
      end else begin
        half_res = {hs, 15'd0} | sub_hm[15:0];
      end
    end
  end

  logic        out_valid_q;
  logic [15:0] dot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      dot_q <= half_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_half_o  = dot_q;
  assign st_o.last     = last_q;
  assign st_o.out_free = !out_valid_q || !out_stall_i;

endmodule

@@ hdl/hfdp_ctrl.sv @@
// Controller: sequences multiply, block flush, lane reduction, tail sum and output.
// Depends on hfdp_pkg; drives the datapath through cmd_t and RAM addresses.
`timescale 1ns / 1ps

module hfdp_ctrl import hfdp_pkg::*; #(
  parameter int Lanes = LANES_DEF,
  localparam int LW  = $clog2(Lanes),
  localparam int PAW = addr_w(Lanes - 1),
  localparam int CW  = $clog2(Lanes + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  status_t        st_i,
  output cmd_t           cmd_o,
  output logic [LW-1:0]  lane_raddr_o,
  output logic [LW-1:0]  lane_waddr_o,
  output logic [PAW-1:0] pend_addr_o
);

  localparam logic [LW-1:0] RedRoot = LW'(red_op(Lanes, 0, RED_ROOT));

  logic [LW-1:0] red_a_tab [Lanes-1];
  logic [LW-1:0] red_b_tab [Lanes-1];

  for (genvar k = 0; k < Lanes - 1; k++) begin : g_red
    assign red_a_tab[k] = LW'(red_op(Lanes, k, RED_A));
    assign red_b_tab[k] = LW'(red_op(Lanes, k, RED_B));
  end

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [1:0]    wcnt_q, wcnt_d;

  logic [LW-1:0] red_a, red_b;
  logic          flush, last_lane;

  assign red_a     = red_a_tab[cnt_q[PAW-1:0]];
  assign red_b     = red_b_tab[cnt_q[PAW-1:0]];
  assign flush     = (phase_q == PH_FLUSH);
  assign last_lane = (cnt_q == CW'(Lanes - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_FLUSH;
      cnt_q   <= '0;
      pos_q   <= '0;
      wcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      wcnt_q  <= wcnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    wcnt_d  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_DEC;
      S_DEC: begin
        cnt_d = '0;
        if (pos_q == LW'(Lanes - 1)) begin
          phase_d = PH_FLUSH;
          state_d = S_RDA;
        end else begin
          pos_d = pos_q + LW'(1);
          if (st_i.last) begin
            phase_d = PH_RED;
            state_d = S_RDA;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RDA: state_d = S_RDB;
      S_RDB: state_d = S_LDB;
      S_LDB: state_d = S_WAIT;
      S_WAIT: begin
        wcnt_d = wcnt_q + 2'd1;
        if (wcnt_q == 2'd3) state_d = S_WB;
      end
      S_WB: begin
        cnt_d = cnt_q + CW'(1);
        unique case (phase_q)
          PH_FLUSH: begin
            if (last_lane) begin
              pos_d = '0;
              if (st_i.last) begin
                phase_d = PH_RED;
                cnt_d   = '0;
                state_d = S_RDA;
              end else begin
                state_d = S_IDLE;
              end
            end else begin
              state_d = S_RDA;
            end
          end
          PH_RED: begin
            state_d = (cnt_q == CW'(Lanes - 2)) ? S_ROOT : S_RDA;
          end
          default: begin
            state_d = (cnt_d == CW'(pos_q)) ? S_OUT : S_TRD;
          end
        endcase
      end
      S_ROOT: state_d = S_ROOTLD;
      S_ROOTLD: begin
        cnt_d = '0;
        if (pos_q == '0) begin
          state_d = S_OUT;
        end else begin
          phase_d = PH_TAIL;
          state_d = S_TRD;
        end
      end
      S_TRD: state_d = S_TLD;
      S_TLD: state_d = S_WAIT;
      S_OUT: begin
        if (st_i.out_free) begin
          pos_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o        = '0;
    lane_raddr_o = '0;
    lane_waddr_o = flush ? cnt_q[LW-1:0] : red_a;
    pend_addr_o  = cnt_q[PAW-1:0];
    in_stall_o   = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: cmd_o.in_load = in_valid_i;
      S_DEC: begin
        pend_addr_o  = pos_q[PAW-1:0];
        cmd_o.pend_we = (pos_q != LW'(Lanes - 1));
      end
      S_RDA: lane_raddr_o = flush ? cnt_q[LW-1:0] : red_a;
      S_RDB: begin
        lane_raddr_o  = red_b;
        cmd_o.opa_sel = OPA_LANE;
      end
      S_LDB: begin
        if (!flush) begin
          cmd_o.opb_sel = OPB_LANE;
        end else if (last_lane) begin
          cmd_o.opb_sel = OPB_PROD;
        end else begin
          cmd_o.opb_sel = OPB_PEND;
        end
      end
      S_WB: begin
        cmd_o.lane_we      = (phase_q != PH_TAIL);
        cmd_o.acc_from_sum = (phase_q == PH_TAIL);
      end
      S_ROOT: lane_raddr_o = RedRoot;
      S_ROOTLD: begin
        lane_raddr_o        = RedRoot;
        cmd_o.acc_from_lane = 1'b1;
      end
      S_TRD: cmd_o.opa_sel = OPA_ACC;
      S_TLD: cmd_o.opb_sel = OPB_PEND;
      S_OUT: begin
        cmd_o.out_load = st_i.out_free;
        cmd_o.lane_clr = st_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/hfdp_checker.sv @@
// Port-level checker for the dot product block, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module hfdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] dot_half_o
);

  // A held result keeps its value until the transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dot_half_o))
    else $error("result changed or dropped while stalled");

  // An accepted transaction always occupies the block for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again right after a transaction");

  // A new result only appears at the end of a busy sequence.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind half_float_dot_product hfdp_checker u_hfdp_checker (.*);
